>>> hw/rtl/pst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PPS second tracker package
// Shared item types and timing constants for the second tracker.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int unsigned IN_DATA_W  = 200;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 128;

  localparam logic signed [31:0] NS_PER_S  = 32'sd1000000000;
  localparam logic signed [31:0] TWO_S_NS  = 32'sd2000000000;
  localparam logic signed [31:0] HALF_S_NS = 32'sd500000000;
  localparam logic signed [31:0] STEP_NS   = 32'sd10000000;
  localparam logic signed [31:0] AGE_MIN   = -32'sd15;
  localparam logic signed [31:0] AGE_MAX   = 32'sd3;
  localparam logic signed [21:0] US_PER_S  = 22'sd1000000;
  localparam logic signed [21:0] TWO_S_US  = 22'sd2000000;
  localparam logic signed [30:0] NS_PER_US = 31'sd1000;
  localparam logic [30:0]        ADJ_RESET = 31'd100000;

  typedef struct packed {
    logic signed [31:0] pulse_sec;
    logic [29:0]        pulse_nsec;
    logic [31:0]        ref_stamp;
    logic               ref_ready;
    logic               ref_copy_ok;
    logic signed [31:0] ref_receive_sec;
    logic [19:0]        ref_receive_usec;
    logic signed [31:0] ref_clk_sec;
    logic [19:0]        ref_clk_usec;
  } item_t;

  typedef struct packed {
    logic signed [31:0] rx_sec;
    logic [29:0]        rx_nsec;
    logic signed [31:0] full_sec;
    logic [29:0]        clock_nsec;
  } res_t;

endpackage
`default_nettype wire

>>> hw/rtl/pst_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PPS second tracker input stage
// Registers one input beat and unpacks it into an item.
// ----------------------------------------------------------------------------
module pst_in_stage (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output      logic                             s_axis_tready_o,
  input  wire logic [pst_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  wire logic [pst_pkg::IN_USER_W-1:0]    s_axis_tuser_i,
  input  wire logic                             take_i,
  output      logic                             valid_o,
  output      pst_pkg::item_t                   item_o
);

  logic           valid_q, valid_d;
  pst_pkg::item_t item_q, item_d;
  logic           accept;

  assign s_axis_tready_o = !valid_q || take_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    item_d                  = item_q;
    valid_d                 = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d                 = 1'b1;
      item_d.pulse_sec        = $signed(s_axis_tdata_i[31:0]);
      item_d.pulse_nsec       = s_axis_tdata_i[61:32];
      item_d.ref_stamp        = s_axis_tdata_i[93:62];
      item_d.ref_receive_sec  = $signed(s_axis_tdata_i[125:94]);
      item_d.ref_receive_usec = s_axis_tdata_i[145:126];
      item_d.ref_clk_sec      = $signed(s_axis_tdata_i[177:146]);
      item_d.ref_clk_usec     = s_axis_tdata_i[197:178];
      item_d.ref_ready        = s_axis_tuser_i[0];
      item_d.ref_copy_ok      = s_axis_tuser_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

>>> hw/rtl/pst_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PPS second tracker core logic
// Holds the tracked offset and forms one result per beat with a new reference stamp once an offset is valid.
// ----------------------------------------------------------------------------
module pst_tracker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [30:0]    cfg_wdata_i,
  input  wire logic           fire_i,
  input  wire pst_pkg::item_t item_i,
  output      logic           res_valid_o,
  output      pst_pkg::res_t  res_o
);

  logic [30:0]        adjust_q;
  logic [31:0]        last_stamp_q;
  logic               offset_valid_q;
  logic signed [31:0] offset_sec_q, offset_sec_d;
  logic signed [30:0] offset_nsec_q, offset_nsec_d;

  logic               stamp_new, age_ok, load, valid_n;
  logic signed [31:0] age;
  logic signed [21:0] ou_raw, ou;
  logic signed [31:0] os_base, os_load;
  logic signed [30:0] load_nsec;
  logic signed [31:0] cur_sec;
  logic signed [30:0] cur_nsec;
  logic signed [31:0] cur_nsec_ext, cn_raw, cn, cs_raw, cs;
  logic signed [31:0] nsec_c;
  logic signed [31:0] adj_ext, dn, cs_out;

  assign stamp_new = item_i.ref_stamp != last_stamp_q;
  assign age       = item_i.ref_receive_sec - item_i.pulse_sec;
  assign age_ok    = (age >= pst_pkg::AGE_MIN) && (age <= pst_pkg::AGE_MAX);
  assign load      = stamp_new && item_i.ref_ready && item_i.ref_copy_ok && age_ok;
  assign valid_n   = offset_valid_q || load;

  assign ou_raw  = $signed({2'b00, item_i.ref_clk_usec})
                 - $signed({2'b00, item_i.ref_receive_usec});
  assign os_base = item_i.ref_clk_sec - item_i.ref_receive_sec;

  always_comb begin
    priority if (ou_raw <= -pst_pkg::US_PER_S) begin
      ou      = ou_raw + pst_pkg::US_PER_S;
      os_load = os_base - 32'sd1;
    end else if (ou_raw > pst_pkg::US_PER_S) begin
      ou      = ou_raw - pst_pkg::TWO_S_US;
      os_load = os_base + 32'sd2;
    end else if (ou_raw > 22'sd0) begin
      ou      = ou_raw - pst_pkg::US_PER_S;
      os_load = os_base + 32'sd1;
    end else begin
      ou      = ou_raw;
      os_load = os_base;
    end
  end

  assign load_nsec = $signed({{9{ou[21]}}, ou}) * pst_pkg::NS_PER_US;

  assign cur_sec      = load ? os_load : offset_sec_q;
  assign cur_nsec     = load ? load_nsec : offset_nsec_q;
  assign cur_nsec_ext = $signed({cur_nsec[30], cur_nsec});
  assign cn_raw       = cur_nsec_ext + $signed({2'b00, item_i.pulse_nsec});
  assign cs_raw       = cur_sec + item_i.pulse_sec;

  always_comb begin
    priority if (cn_raw < -pst_pkg::HALF_S_NS) begin
      cn = cn_raw + pst_pkg::NS_PER_S;
      cs = cs_raw - 32'sd1;
    end else if (cn_raw >= pst_pkg::HALF_S_NS) begin
      cn = cn_raw - pst_pkg::NS_PER_S;
      cs = cs_raw + 32'sd1;
    end else begin
      cn = cn_raw;
      cs = cs_raw;
    end
  end

  always_comb begin
    priority if (cn > pst_pkg::STEP_NS) begin
      nsec_c = cur_nsec_ext - pst_pkg::STEP_NS;
    end else if (cn < -pst_pkg::STEP_NS) begin
      nsec_c = cur_nsec_ext + pst_pkg::STEP_NS;
    end else begin
      nsec_c = cur_nsec_ext - (cn >>> 4);
    end
  end

  always_comb begin
    logic signed [31:0] wrapped;
    priority if (nsec_c <= -pst_pkg::NS_PER_S) begin
      wrapped      = nsec_c + pst_pkg::NS_PER_S;
      offset_sec_d = cur_sec - 32'sd1;
    end else if (nsec_c > 32'sd0) begin
      wrapped      = nsec_c - pst_pkg::NS_PER_S;
      offset_sec_d = cur_sec + 32'sd1;
    end else begin
      wrapped      = nsec_c;
      offset_sec_d = cur_sec;
    end
    offset_nsec_d = wrapped[30:0];
  end

  assign adj_ext = $signed({adjust_q[30], adjust_q});

  always_comb begin
    priority if (adj_ext < -pst_pkg::NS_PER_S) begin
      dn     = adj_ext + pst_pkg::TWO_S_NS;
      cs_out = cs - 32'sd2;
    end else if (adj_ext < 32'sd0) begin
      dn     = adj_ext + pst_pkg::NS_PER_S;
      cs_out = cs - 32'sd1;
    end else begin
      dn     = adj_ext;
      cs_out = cs;
    end
  end

  assign res_valid_o      = fire_i && stamp_new && valid_n;
  assign res_o.rx_sec     = item_i.pulse_sec;
  assign res_o.rx_nsec    = item_i.pulse_nsec;
  assign res_o.full_sec   = cs_out;
  assign res_o.clock_nsec = dn[29:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adjust_q       <= pst_pkg::ADJ_RESET;
      last_stamp_q   <= '0;
      offset_valid_q <= 1'b0;
      offset_sec_q   <= '0;
      offset_nsec_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        adjust_q <= cfg_wdata_i;
      end
      if (fire_i && stamp_new) begin
        if (item_i.ref_ready) begin
          last_stamp_q <= item_i.ref_stamp;
        end
        if (valid_n) begin
          offset_valid_q <= 1'b1;
          offset_sec_q   <= offset_sec_d;
          offset_nsec_q  <= offset_nsec_d;
        end
      end
    end
  end

`ifndef SYNTH
  a_nsec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (offset_nsec_q <= 31'sd0) && ($signed({offset_nsec_q[30], offset_nsec_q}) >
      -pst_pkg::NS_PER_S))
    else $error("tracked offset nanoseconds left (-1 s, 0]");
  a_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(offset_valid_q))
    else $error("offset valid flag cleared");
  a_same_stamp_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (item_i.ref_stamp == last_stamp_q)) |-> !res_valid_o)
    else $error("result for an unchanged stamp");
  a_result_valid_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> offset_valid_q)
    else $error("result without a valid offset");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/pst_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PPS second tracker output stage
// Result register that drives the output stream and packs its beat.
// ----------------------------------------------------------------------------
module pst_out_stage (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           res_valid_i,
  input  wire pst_pkg::res_t                  res_i,
  output      logic                           slot_free_o,
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output      logic [pst_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic          valid_q, valid_d;
  pst_pkg::res_t res_q;

  assign slot_free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
    if (res_valid_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {4'b0000, res_q.clock_nsec, res_q.full_sec,
                            res_q.rx_nsec, res_q.rx_sec};

endmodule
`default_nettype wire

>>> hw/rtl/pps_second_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PPS second tracker
// Each input beat carries one captured pulse and a coarse reference snapshot.
// When the snapshot stamp changes, the block may load a new second offset
// from the snapshot, then tracks and corrects the offset and emits one output
// beat with the capture time and the full-second time plus the delay.
// Beats with an unchanged stamp, or before any offset is valid, emit nothing.
// The delay register is written through cfg_we_i/cfg_wdata_i. The user must
// write it only while idle; the block itself does not enforce this. An input
// beat is held in the input register; the tracking logic works on it, and the
// offset state and the output register are updated together when it fires.
// One beat is taken per cycle as long as the output register can take a result.
// Reset clears the stored stamp, the offset and its valid flag, and sets the
// delay to 100000 ns. When the receiver stalls, the result waits in the output
// register, one more beat is held in the input register, and then tready
// falls until the output is taken.
// ----------------------------------------------------------------------------
module pps_second_tracker_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [30:0]                    cfg_wdata_i,
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  // pulse_sec, pulse_nsec, ref_stamp, ref_receive_sec, ref_receive_usec,
  // ref_clk_sec, ref_clk_usec, two bits of zero fill
  input  wire logic [pst_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // ref_ready, ref_copy_ok
  input  wire logic [pst_pkg::IN_USER_W-1:0]  s_axis_tuser_i,
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // rx_sec, rx_nsec, full_sec, clock_nsec, four bits of zero fill
  output      logic [pst_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic           in_valid, slot_free, fire, res_valid;
  pst_pkg::item_t item;
  pst_pkg::res_t  res;

  assign fire = in_valid && slot_free;

  pst_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .take_i          (fire),
    .valid_o         (in_valid),
    .item_o          (item)
  );

  pst_tracker u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pst_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (res_valid),
    .res_i           (res),
    .slot_free_o     (slot_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

>>> test/pulse_tracker_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPS second tracker result checker
// Watches the delay register port and both stream channels of the tracker,
// keeps its own copy of the stored stamp, the tracked second offset and the
// delay, predicts the output beat, if any, of every accepted input beat and
// compares each accepted output beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pulse_tracker_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [30:0]                    cfg_wdata_i,
  input  wire logic                           s_tvalid_i,
  input  wire logic                           s_tready_i,
  input  wire logic [pst_pkg::IN_DATA_W-1:0]  s_tdata_i,
  input  wire logic [pst_pkg::IN_USER_W-1:0]  s_tuser_i,
  input  wire logic                           m_tvalid_i,
  input  wire logic                           m_tready_i,
  input  wire logic [pst_pkg::OUT_DATA_W-1:0] m_tdata_i,
  output int                                  pending_o,
  output int                                  errors_o,
  output int                                  results_o
);
  import pst_pkg::*;

  localparam longint SEC_NS       = 1000000000;
  localparam longint HALF_SEC_NS  = 500000000;
  localparam longint CORR_STEP_NS = 10000000;
  localparam longint USEC_PER_SEC = 1000000;
  localparam longint NS_PER_USEC  = 1000;

  logic [31:0]        stored_stamp;
  bit                 offset_ok;
  logic [31:0]        offset_sec;
  longint             offset_nsec;
  logic signed [30:0] delay_ns;
  res_t               expected_pulses[$];
  int                 mismatches;
  int                 results_seen;

  function automatic bit track_pulse(input item_t it, output res_t r);
    logic signed [31:0] age;
    logic [31:0]        os;
    logic [31:0]        cs;
    longint             ou;
    longint             cn;
    longint             corr;
    longint             dly;
    r = '0;
    if (it.ref_stamp == stored_stamp) return 1'b0;
    if (it.ref_ready) begin
      stored_stamp = it.ref_stamp;
      age = it.ref_receive_sec - it.pulse_sec;
      if (it.ref_copy_ok && age >= AGE_MIN && age <= AGE_MAX) begin
        os = it.ref_clk_sec - it.ref_receive_sec;
        ou = longint'(it.ref_clk_usec) - longint'(it.ref_receive_usec);
        while (ou <= -USEC_PER_SEC) begin
          ou = ou + USEC_PER_SEC;
          os = os - 32'd1;
        end
        while (ou > 0) begin
          ou = ou - USEC_PER_SEC;
          os = os + 32'd1;
        end
        offset_sec  = os;
        offset_nsec = ou * NS_PER_USEC;
        offset_ok   = 1'b1;
      end
    end
    if (!offset_ok) return 1'b0;

    cs = offset_sec + it.pulse_sec;
    cn = offset_nsec + longint'(it.pulse_nsec);
    while (cn < -HALF_SEC_NS) begin
      cn = cn + SEC_NS;
      cs = cs - 32'd1;
    end
    while (cn >= HALF_SEC_NS) begin
      cn = cn - SEC_NS;
      cs = cs + 32'd1;
    end

    // The residual pulls the offset by a clamped step or by a floored 1/16.
    if (cn > CORR_STEP_NS) begin
      corr = CORR_STEP_NS;
    end else if (cn < -CORR_STEP_NS) begin
      corr = -CORR_STEP_NS;
    end else if (cn < 0) begin
      corr = -((-cn + 15) / 16);
    end else begin
      corr = cn / 16;
    end
    offset_nsec = offset_nsec - corr;
    if (offset_nsec <= -SEC_NS) begin
      offset_nsec = offset_nsec + SEC_NS;
      offset_sec  = offset_sec - 32'd1;
    end
    if (offset_nsec > 0) begin
      offset_nsec = offset_nsec - SEC_NS;
      offset_sec  = offset_sec + 32'd1;
    end

    dly = delay_ns;
    while (dly < 0) begin
      dly = dly + SEC_NS;
      cs  = cs - 32'd1;
    end

    r.rx_sec     = it.pulse_sec;
    r.rx_nsec    = it.pulse_nsec;
    r.full_sec   = cs;
    r.clock_nsec = dly[29:0];
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: result beat %0d: %s", results_seen, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    res_t  want;
    res_t  got;
    if (!rst_ni) begin
      stored_stamp = '0;
      offset_ok    = 1'b0;
      offset_sec   = '0;
      offset_nsec  = 0;
      delay_ns     = ADJ_RESET;
      expected_pulses.delete();
      mismatches   = 0;
      results_seen = 0;
      pending_o <= 0;
      errors_o  <= 0;
      results_o <= 0;
    end else begin
      if (cfg_we_i) delay_ns = cfg_wdata_i;

      if (s_tvalid_i && s_tready_i) begin
        it.pulse_sec        = s_tdata_i[31:0];
        it.pulse_nsec       = s_tdata_i[61:32];
        it.ref_stamp        = s_tdata_i[93:62];
        it.ref_receive_sec  = s_tdata_i[125:94];
        it.ref_receive_usec = s_tdata_i[145:126];
        it.ref_clk_sec      = s_tdata_i[177:146];
        it.ref_clk_usec     = s_tdata_i[197:178];
        it.ref_ready        = s_tuser_i[0];
        it.ref_copy_ok      = s_tuser_i[1];
        if (track_pulse(it, want)) expected_pulses.push_back(want);
      end

      if (m_tvalid_i && m_tready_i) begin
        got.rx_sec     = m_tdata_i[31:0];
        got.rx_nsec    = m_tdata_i[61:32];
        got.full_sec   = m_tdata_i[93:62];
        got.clock_nsec = m_tdata_i[123:94];
        if (expected_pulses.size() == 0) begin
          note_mismatch($sformatf("no result expected, got rx_sec %0d full_sec %0d",
                                  got.rx_sec, got.full_sec));
        end else begin
          want = expected_pulses.pop_front();
          if (got.rx_sec !== want.rx_sec)
            note_mismatch($sformatf("rx_sec expected %0d, got %0d", want.rx_sec, got.rx_sec));
          if (got.rx_nsec !== want.rx_nsec)
            note_mismatch($sformatf("rx_nsec expected %0d, got %0d",
                                    want.rx_nsec, got.rx_nsec));
          if (got.full_sec !== want.full_sec)
            note_mismatch($sformatf("full_sec expected %0d, got %0d",
                                    want.full_sec, got.full_sec));
          if (got.clock_nsec !== want.clock_nsec)
            note_mismatch($sformatf("clock_nsec expected %0d, got %0d",
                                    want.clock_nsec, got.clock_nsec));
        end
        results_seen++;
      end

      pending_o <= expected_pulses.size();
      errors_o  <= mismatches;
      results_o <= results_seen;
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPS second tracker testbench
// Drives pulse and reference snapshot beats into the tracker: a directed set
// covering stale stamps, rejected snapshots, age limits, wrapped seconds and
// oversized fields, then random tracking runs mixed with noise, under several
// delay settings and with random gaps and output stalls. The checker beside
// the block predicts and compares every output beat.
// ----------------------------------------------------------------------------
module testbench;
  import pst_pkg::*;

  localparam int     IDLE_LIMIT    = 2000;
  localparam int     RANDOM_PHASES = 9;
  localparam int     PHASE_BEATS   = 220;
  localparam longint SEC_NS        = 1000000000;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [30:0]           cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [IN_USER_W-1:0]  s_tuser   = '0;
  logic                  m_tready  = 1'b0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [OUT_DATA_W-1:0] m_tdata;

  int          pending_cnt;
  int          error_cnt;
  int          result_cnt;
  bit          gaps_on;
  bit          stall_on;
  int          beats_sent;
  int          delay_writes;
  int          stall_left;
  int          stall_pick;
  int          idle_cycles;
  int          seq_left;
  int          seq_frac;
  logic [31:0] seq_sec;
  logic [31:0] seq_off;
  logic [31:0] stamp_ctr;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  pps_second_tracker_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  pulse_tracker_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .pending_o   (pending_cnt),
    .errors_o    (error_cnt),
    .results_o   (result_cnt)
  );

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!stall_on || !m_tready) begin
      m_tready <= 1'b1;
      stall_left = $urandom_range(0, 15);
    end else begin
      m_tready <= 1'b0;
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 85) begin
        stall_left = $urandom_range(0, 2);
      end else if (stall_pick < 97) begin
        stall_left = $urandom_range(3, 9);
      end else begin
        stall_left = $urandom_range(20, 59);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timed out after %0d cycles without a beat.", idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic item_t pulse_item(input logic [31:0] psec, input logic [29:0] pnsec,
                                       input logic [31:0] stamp, input bit ready,
                                       input bit copy_ok, input logic [31:0] rsec,
                                       input logic [19:0] rusec, input logic [31:0] csec,
                                       input logic [19:0] cusec);
    item_t it;
    it.pulse_sec        = psec;
    it.pulse_nsec       = pnsec;
    it.ref_stamp        = stamp;
    it.ref_ready        = ready;
    it.ref_copy_ok      = copy_ok;
    it.ref_receive_sec  = rsec;
    it.ref_receive_usec = rusec;
    it.ref_clk_sec      = csec;
    it.ref_clk_usec     = cusec;
    return it;
  endfunction

  task automatic send_beat(input item_t it);
    int pick;
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, it.ref_clk_usec, it.ref_clk_sec, it.ref_receive_usec,
                 it.ref_receive_sec, it.ref_stamp, it.pulse_nsec, it.pulse_sec};
    s_tuser  <= {it.ref_copy_ok, it.ref_ready};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    beats_sent++;
    gap = 0;
    if (gaps_on) begin
      pick = $urandom_range(0, 99);
      if (pick >= 97) begin
        gap = $urandom_range(20, 60);
      end else if (pick >= 88) begin
        gap = $urandom_range(4, 10);
      end else if (pick >= 55) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_block();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_delay(input logic [30:0] value);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    delay_writes++;
  endtask

  initial begin
    item_t       it;
    logic [30:0] dly;
    int          pick;
    int          age;
    int          jit;
    int          rusec;
    longint      ns;

    repeat (12) @(posedge clk_i);
    rst_ni   <= 1'b1;
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    @(posedge clk_i);

    send_beat(pulse_item(1000, 0, 0, 1, 1, 990, 0, 5000, 0));
    send_beat(pulse_item(1001, 0, 1, 0, 1, 995, 0, 5000, 0));
    send_beat(pulse_item(1002, 0, 2, 1, 0, 995, 0, 5000, 0));
    send_beat(pulse_item(1003, 0, 3, 1, 1, 1007, 0, 5000, 0));
    send_beat(pulse_item(1004, 0, 4, 1, 1, 988, 0, 5000, 0));
    send_beat(pulse_item(1005, 600000000, 5, 1, 1, 990, 500000, 9000, 250000));
    send_beat(pulse_item(1006, 600000000, 5, 1, 1, 990, 500000, 9000, 250000));
    send_beat(pulse_item(1006, 750000000, 6, 0, 0, 0, 0, 0, 0));
    send_beat(pulse_item(1007, 999999999, 7, 1, 0, 0, 0, 0, 0));
    send_beat(pulse_item(1008, 0, 8, 1, 1, 1011, 0, 7000, 20'hFFFFF));
    send_beat(pulse_item(1009, 30'h3FFFFFFF, 9, 1, 1, 1009, 20'hFFFFF, 7000, 0));
    send_beat(pulse_item(32'h7FFFFFFF, 5000000, 10, 1, 1, 32'h80000001, 123456,
                         32'h80000000, 999999));
    send_beat(pulse_item(32'h80000000, 20000000, 11, 1, 1, 32'h7FFFFFF1, 0,
                         32'h7FFFFFFF, 0));
    send_beat(pulse_item(32'h80000001, 985000000, 32'hFFFFFFFF, 0, 1, 0, 0, 0, 0));
    send_beat(pulse_item(32'h7FFFFFFF, 0, 12, 1, 1, 32'h80000010, 0, 0, 0));
    send_beat(pulse_item(0, 499999999, 13, 1, 1, 0, 999999, 0, 0));
    send_beat(pulse_item(1, 500000000, 14, 1, 1, 32'hFFFFFFF2, 0, 3, 999999));

    set_delay(31'h40000000);
    send_beat(pulse_item(2, 3000000, 15, 0, 0, 0, 0, 0, 0));
    send_beat(pulse_item(3, 997000000, 16, 0, 1, 0, 0, 0, 0));
    set_delay(31'h3FFFFFFF);
    send_beat(pulse_item(4, 0, 17, 0, 0, 0, 0, 0, 0));
    send_beat(pulse_item(5, 1000000, 18, 1, 0, 0, 0, 0, 0));
    set_delay('1);
    send_beat(pulse_item(6, 0, 19, 0, 0, 0, 0, 0, 0));

    stamp_ctr = 19;
    seq_left  = 0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       dly = 31'd0;
        1:       dly = 31'd999999999;
        2:       dly = -31'sd999999999;
        3:       dly = 31'h3FFFFFFF;
        4:       dly = 31'h40000000;
        5:       dly = '1;
        6:       dly = 31'd100000;
        default: dly = 31'($urandom);
      endcase
      set_delay(dly);
      gaps_on  = (ph % 3 != 0);
      stall_on = (ph % 3 != 0);

      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (seq_left == 0) begin
          seq_left = $urandom_range(4, 40);
          seq_sec  = $urandom;
          seq_off  = $urandom;
          seq_frac = $urandom_range(0, 999999);
        end
        seq_left--;

        if ($urandom_range(0, 99) < 15) begin
          it = pulse_item($urandom, 30'($urandom), $urandom, 1'($urandom), 1'($urandom),
                          $urandom, 20'($urandom), $urandom, 20'($urandom));
          stamp_ctr = it.ref_stamp;
        end else begin
          seq_sec = seq_sec + 32'd1;
          pick = $urandom_range(0, 99);
          if (pick < 70) begin
            jit = int'($urandom_range(0, 10000000)) - 5000000;
          end else if (pick < 85) begin
            jit = int'($urandom_range(0, 100000000)) - 50000000;
          end else begin
            jit = $urandom_range(0, 999999999);
          end
          ns = SEC_NS - longint'(seq_frac) * 1000 + jit;
          while (ns < 0) ns = ns + SEC_NS;
          while (ns >= SEC_NS) ns = ns - SEC_NS;

          if ($urandom_range(0, 99) < 90) begin
            age = int'($urandom_range(0, 18)) - 15;
          end else begin
            age = int'($urandom_range(0, 60)) - 30;
          end
          if ($urandom_range(0, 99) >= 8) stamp_ctr = stamp_ctr + 32'd1;
          rusec = $urandom_range(0, 999999);

          it.pulse_sec        = seq_sec;
          it.pulse_nsec       = ns[29:0];
          it.ref_stamp        = stamp_ctr;
          it.ref_receive_sec  = seq_sec + age;
          it.ref_clk_sec      = it.ref_receive_sec + seq_off;
          it.ref_receive_usec = 20'(rusec);
          it.ref_clk_usec     = 20'((rusec + seq_frac) % 1000000);
          if ($urandom_range(0, 99) < 3) it.pulse_nsec = 30'($urandom);
          if ($urandom_range(0, 99) < 3) begin
            it.ref_receive_usec = 20'($urandom);
            it.ref_clk_usec     = 20'($urandom);
          end

          pick = $urandom_range(0, 99);
          if (pick < 5) begin
            it.ref_ready   = 1'b0;
            it.ref_copy_ok = 1'($urandom);
          end else begin
            it.ref_ready   = 1'b1;
            it.ref_copy_ok = (pick >= 10);
          end
        end
        send_beat(it);
      end
    end

    drain_block();
    $display("Summary: %0d input beats under %0d delay settings, %0d output beats checked.",
             beats_sent, delay_writes + 1, result_cnt);
    $display("Covered tracking runs, stale stamps, rejected or aged snapshots and noise.");
    if (error_cnt == 0 && pending_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
